@@ rtl/core/m4v_pkg.sv @@
// Shared constants, types and reset values for the 4x4 matrix by vector transform.
// Used by m4v_lane, m4v_merge and mat4_vec4_transform; depends on nothing else.
package m4v_pkg;

    localparam int FRAC_BITS = 16;              // fractional bits of the fixed-point format
    localparam int ELEM_W    = 32;              // width of one matrix or vector element
    localparam int DIM       = 4;               // rows, columns and vector length
    localparam int NUM_CFG   = 8;               // configuration registers
    localparam int CFG_W     = 2 * ELEM_W;      // width of one configuration register
    localparam int CFG_IDX_W = $clog2(NUM_CFG);
    localparam int PROD_W    = 2 * ELEM_W;      // full product width
    localparam int SHIFT_W   = PROD_W - FRAC_BITS;  // product after dropping fraction bits
    localparam int PAIR_W    = SHIFT_W + 1;     // sum of two shifted products
    localparam int SUM_W     = SHIFT_W + 2;     // sum of four shifted products
    localparam int VEC_W     = DIM * ELEM_W;    // packed vector on the stream

    // Fixed-point one, used to build the identity matrix at reset.
    localparam logic [ELEM_W-1:0] FX_ONE = ELEM_W'(1) << FRAC_BITS;

    // Register codes, in the order of the register list.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COL0_ROWS01 = CFG_IDX_W'(0),
        CFG_COL0_ROWS23 = CFG_IDX_W'(1),
        CFG_COL1_ROWS01 = CFG_IDX_W'(2),
        CFG_COL1_ROWS23 = CFG_IDX_W'(3),
        CFG_COL2_ROWS01 = CFG_IDX_W'(4),
        CFG_COL2_ROWS23 = CFG_IDX_W'(5),
        CFG_COL3_ROWS01 = CFG_IDX_W'(6),
        CFG_COL3_ROWS23 = CFG_IDX_W'(7)
    } t_cfg_idx;

    // Load enables of the three pipeline stages.
    typedef struct packed {
        logic s1;   // products
        logic s2;   // pair sums
        logic s3;   // final sum, saturation and output register
    } t_stage_en;

    // Reset value of a register: identity matrix, the one sits in the low half for
    // even rows and in the high half for odd rows.
    function automatic logic [CFG_W-1:0] cfg_reset(input t_cfg_idx idx);
        logic [CFG_W-1:0] val;
        val = '0;
        unique case (idx)
            CFG_COL0_ROWS01: val = {{ELEM_W{1'b0}}, FX_ONE};
            CFG_COL1_ROWS01: val = {FX_ONE, {ELEM_W{1'b0}}};
            CFG_COL2_ROWS23: val = {{ELEM_W{1'b0}}, FX_ONE};
            CFG_COL3_ROWS23: val = {FX_ONE, {ELEM_W{1'b0}}};
            CFG_COL0_ROWS23, CFG_COL1_ROWS23,
            CFG_COL2_ROWS01, CFG_COL3_ROWS01: val = '0;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

@@ rtl/core/m4v_lane.sv @@
// One row lane: four signed products, two pair sums, final sum and saturation.
// Depends on m4v_pkg for widths and the stage enable struct.
module m4v_lane (
    input  logic                         i_clk,
    input  m4v_pkg::t_stage_en           i_en,
    input  logic [m4v_pkg::ELEM_W-1:0]   i_row [m4v_pkg::DIM],  // matrix row, column 0 first
    input  logic [m4v_pkg::ELEM_W-1:0]   i_vec [m4v_pkg::DIM],  // vector, element 0 first
    output logic [m4v_pkg::ELEM_W-1:0]   o_sum,
    output logic                         o_sat
);

    logic signed [m4v_pkg::PROD_W-1:0] r_prod [m4v_pkg::DIM];
    logic signed [m4v_pkg::PROD_W-1:0] n_prod [m4v_pkg::DIM];
    logic signed [m4v_pkg::PAIR_W-1:0] r_pair [2];
    logic signed [m4v_pkg::PAIR_W-1:0] n_pair [2];
    logic signed [m4v_pkg::SUM_W-1:0]  sum;
    logic                              fits;

    always_comb begin
        for (int c = 0; c < m4v_pkg::DIM; c++) begin
            n_prod[c] = $signed(i_row[c]) * $signed(i_vec[c]);
        end
        // Dropping the fraction bits of a two's complement product rounds down.
        for (int p = 0; p < 2; p++) begin
            n_pair[p] = m4v_pkg::PAIR_W'($signed(r_prod[2*p][m4v_pkg::PROD_W-1:m4v_pkg::FRAC_BITS]))
                      + m4v_pkg::PAIR_W'($signed(r_prod[2*p+1][m4v_pkg::PROD_W-1:m4v_pkg::FRAC_BITS]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_prod <= n_prod;
        end
        if (i_en.s2) begin
            r_pair <= n_pair;
        end
    end

    assign sum  = m4v_pkg::SUM_W'(r_pair[0]) + m4v_pkg::SUM_W'(r_pair[1]);
    // The sum fits 32 bits when every bit above bit 30 equals the sign.
    assign fits = (sum[m4v_pkg::SUM_W-1:m4v_pkg::ELEM_W-1] == '0)
               || (sum[m4v_pkg::SUM_W-1:m4v_pkg::ELEM_W-1] == '1);

    always_comb begin
        if (fits) begin
            o_sum = sum[m4v_pkg::ELEM_W-1:0];
        end else if (sum[m4v_pkg::SUM_W-1]) begin
            o_sum = {1'b1, {(m4v_pkg::ELEM_W-1){1'b0}}};
        end else begin
            o_sum = {1'b0, {(m4v_pkg::ELEM_W-1){1'b1}}};
        end
        o_sat = !fits;
    end

endmodule

@@ rtl/core/m4v_merge.sv @@
// Output stage: gathers the four lane results into the result register and
// combines their saturation flags. Depends on m4v_pkg.
module m4v_merge (
    input  logic                         i_clk,
    input  m4v_pkg::t_stage_en           i_en,
    input  logic [m4v_pkg::ELEM_W-1:0]   i_row_sum [m4v_pkg::DIM],
    input  logic [m4v_pkg::DIM-1:0]      i_row_sat,
    output logic [m4v_pkg::VEC_W-1:0]    o_data,
    output logic                         o_ovf
);

    logic [m4v_pkg::VEC_W-1:0] r_data;
    logic [m4v_pkg::VEC_W-1:0] n_data;
    logic                      r_ovf;

    always_comb begin
        for (int r = 0; r < m4v_pkg::DIM; r++) begin
            n_data[r*m4v_pkg::ELEM_W +: m4v_pkg::ELEM_W] = i_row_sum[r];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_data <= n_data;
            r_ovf  <= |i_row_sat;
        end
    end

    assign o_data = r_data;
    assign o_ovf  = r_ovf;

endmodule

@@ rtl/core/mat4_vec4_transform.sv @@
// Top level of the 4x4 matrix by 4-vector transform in signed fixed point.
// Depends on m4v_pkg, m4v_lane and m4v_merge.
//
// Channel   Direction  Handshake                    Payload
// cfg       in         i_cfg_valid / o_cfg_ready    i_cfg_index (register), i_cfg_data (64 bits)
// s_axis    in         s_axis_tvalid / tready       tdata: in_x, in_y, in_z, in_w
// m_axis    out        m_axis_tvalid / tready       tdata: out_x..out_w, tuser: overflow
//
// One vector is taken every cycle while s_axis_tready is high, and its result passes through
// a stage of sixteen 32x32 multipliers (four per row lane), a stage of pair sums,
// then the final add with saturation, which loads the output register.
// Each stage holds its request while the stage after it is full and stalled, so a
// bubble in the pipeline still lets a new request in while the output waits.
// Reset (i_rst_n low, synchronous) empties the pipeline and loads the identity
// matrix. Configuration is always ready and takes effect on the next request.
module mat4_vec4_transform (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [m4v_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [m4v_pkg::CFG_W-1:0]         i_cfg_data,
    // input vectors
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [m4v_pkg::VEC_W-1:0]         s_axis_tdata,   // in_x, in_y, in_z, in_w from bit 0
    // transformed vectors
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [m4v_pkg::VEC_W-1:0]         m_axis_tdata,   // out_x, out_y, out_z, out_w from bit 0
    output logic                              m_axis_tuser    // overflow
);

    // Matrix storage, one register per pair of rows within a column.
    logic [m4v_pkg::CFG_W-1:0]  r_cfg [m4v_pkg::NUM_CFG];

    // Pipeline occupancy flags.
    logic r_v1, r_v2, r_v3;
    logic adv1, adv2, adv3;
    m4v_pkg::t_stage_en en;

    logic [m4v_pkg::ELEM_W-1:0] vec      [m4v_pkg::DIM];
    logic [m4v_pkg::ELEM_W-1:0] mat      [m4v_pkg::DIM][m4v_pkg::DIM];
    logic [m4v_pkg::ELEM_W-1:0] row_sum  [m4v_pkg::DIM];
    logic [m4v_pkg::DIM-1:0]    row_sat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < m4v_pkg::NUM_CFG; i++) begin
                r_cfg[i] <= m4v_pkg::cfg_reset(m4v_pkg::t_cfg_idx'(i));
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    // A stage may load when it is empty or its contents move on this cycle.
    assign adv3          = !r_v3 || m_axis_tready;
    assign adv2          = !r_v2 || adv3;
    assign adv1          = !r_v1 || adv2;
    assign s_axis_tready = adv1;

    assign en.s1 = adv1 && s_axis_tvalid;
    assign en.s2 = adv2 && r_v1;
    assign en.s3 = adv3 && r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= s_axis_tvalid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Element (row r, column c) lives in register 2c + r/2, in the half chosen by r's low bit.
    for (genvar c = 0; c < m4v_pkg::DIM; c++) begin : g_col
        assign vec[c] = s_axis_tdata[c*m4v_pkg::ELEM_W +: m4v_pkg::ELEM_W];
        for (genvar r = 0; r < m4v_pkg::DIM; r++) begin : g_row
            assign mat[r][c] = r_cfg[2*c + r/2][(r%2)*m4v_pkg::ELEM_W +: m4v_pkg::ELEM_W];
        end
    end

    // One lane per result row.
    for (genvar r = 0; r < m4v_pkg::DIM; r++) begin : g_lane
        m4v_lane u_lane (
            .i_clk (i_clk),
            .i_en  (en),
            .i_row (mat[r]),
            .i_vec (vec),
            .o_sum (row_sum[r]),
            .o_sat (row_sat[r])
        );
    end

    m4v_merge u_merge (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_row_sum (row_sum),
        .i_row_sat (row_sat),
        .o_data    (m_axis_tdata),
        .o_ovf     (m_axis_tuser)
    );

    assign m_axis_tvalid = r_v3;

    // An overflow flag comes only with at least one row clamped to a limit.
    a_ovf_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
            (m_axis_tdata[31:0]   == 32'h7fff_ffff || m_axis_tdata[31:0]   == 32'h8000_0000 ||
             m_axis_tdata[63:32]  == 32'h7fff_ffff || m_axis_tdata[63:32]  == 32'h8000_0000 ||
             m_axis_tdata[95:64]  == 32'h7fff_ffff || m_axis_tdata[95:64]  == 32'h8000_0000 ||
             m_axis_tdata[127:96] == 32'h7fff_ffff || m_axis_tdata[127:96] == 32'h8000_0000))
        else $error("overflow flagged without a saturated row");

    // With the output register empty the pipeline can always take a request.
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output register empty");

    // A request taken into an empty pipeline with a free output reaches the pair sum stage.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && !r_v1 && !r_v2 && !r_v3 && m_axis_tready)
            |=> ##1 (r_v2 || !i_rst_n))
        else $error("request lost between stages");

    // The pipeline comes out of reset empty.
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result shown straight after reset");

endmodule
